### src/cst_pkg.sv
// ----------------------------------------------------------------------------
// Counting semaphore table package
// Sizes, operation and status codes, and the record types that are shared
// by the controller and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

  // Table sizes
  localparam int NUM_SEMAPHORES = 256;
  localparam int NUM_PROCESSES  = 16;
  localparam int COUNT_WIDTH    = 8;

  localparam int KEY_W   = (NUM_SEMAPHORES > 2) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int PROC_W  = (NUM_PROCESSES > 2) ? $clog2(NUM_PROCESSES) : 1;

  // The free-key search looks at this many keys per cycle.
  localparam int CHUNK      = 16;
  localparam int CHUNK_SEL_W = $clog2(CHUNK);
  localparam int NUM_CHUNKS = (NUM_SEMAPHORES + CHUNK - 1) / CHUNK;
  localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  // Operation codes
  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_DOWN    = 3'd2,
    OP_UP      = 3'd3,
    OP_RELEASE = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_QUEUED = 2'd1,
    ST_NOFREE = 2'd2,
    ST_BADKEY = 2'd3
  } status_e;

  // One row of the per-semaphore memory.
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic [PROC_W-1:0]      owner;
    logic                   head_v;
    logic [PROC_W-1:0]      head_p;
    logic [PROC_W-1:0]      tail;
  } row_t;

  // Request as captured from the input channel.
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] sem_key;
    logic [3:0] process_id;
    logic [7:0] start_count;
  } req_t;

  // Result as handed to the output register.
  typedef struct packed {
    status_e    status;
    logic [7:0] new_key;
    logic       woken_valid;
    logic [3:0] woken_process;
  } result_t;

  // Folds a process number into the process table by repeated subtraction.
  function automatic logic [PROC_W-1:0] pid_fold(input logic [3:0] p);
    logic [3:0] v;
    v = p;
    for (int i = 0; i < 8; i++) begin
      if (int'(v) >= NUM_PROCESSES) begin
        v = v - 4'(NUM_PROCESSES);
      end
    end
    return PROC_W'(v);
  endfunction

endpackage

`default_nettype wire

### src/cst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### src/cst_ctrl.sv
// ----------------------------------------------------------------------------
// Counting semaphore table sequencer
// Runs one request at a time over the semaphore memory, the allocation
// flags and the per-process wait links.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire cst_pkg::req_t     req_i,
  output logic                   busy_o,
  output logic                   res_valid_o,
  output cst_pkg::result_t       res_o,
  input  wire logic              res_take_i
);
  import cst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DOWN,
    S_UP,
    S_REL_RD,
    S_REL_CHK,
    S_UNL_START,
    S_UNL_ROW,
    S_UNL_WALK,
    S_FIN
  } state_e;

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  state_e                 state_q;
  op_e                    op_q;
  logic [KEY_W-1:0]       key_q;
  logic [PROC_W-1:0]      pid_q;
  logic [7:0]             init_q;
  logic [CHUNK_W-1:0]     chunk_q;
  logic [KEY_W-1:0]       idx_q;
  result_t                res_q;
  row_t                   row_q;
  logic                   cur_v_q;
  logic [PROC_W-1:0]      cur_p_q;
  logic [PROC_W-1:0]      prev_q;
  logic                   has_prev_q;

  logic [NUM_SEMAPHORES-1:0] alloc_q;
  logic [NUM_PROCESSES-1:0]  wait_v_q;
  logic [KEY_W-1:0]          wait_key_q [NUM_PROCESSES];
  logic                      nw_v_q [NUM_PROCESSES];
  logic [PROC_W-1:0]         nw_p_q [NUM_PROCESSES];

  logic                   ram_we_q;
  logic [KEY_W-1:0]       ram_waddr_q;
  row_t                   ram_wdata_q;
  logic [KEY_W-1:0]       ram_raddr;
  logic [$bits(row_t)-1:0] ram_rdata;
  row_t                   rd_row;

  logic                   key_ok;
  logic [PROC_W-1:0]      pid_in;
  logic [KEY_W-1:0]       key_in;

  logic [NUM_CHUNKS*CHUNK-1:0] free_pad;
  logic [CHUNK-1:0]       chunk_bits;
  logic                   scan_found;
  logic [CHUNK_SEL_W-1:0] scan_sel;
  logic [KEY_W-1:0]       scan_key;

  logic [PROC_W-1:0]      nw_raddr;
  logic                   nw_rd_v;
  logic [PROC_W-1:0]      nw_rd_p;

  logic [COUNT_WIDTH-1:0] init_sat;
  row_t                   row_new;
  row_t                   row_dec;
  row_t                   row_enq;
  row_t                   row_deq;
  row_t                   row_inc;
  row_t                   row_unl;

  // Semaphore memory: count, owner and queue ends of each key.
  cst_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (1 << KEY_W)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we_q),
    .waddr_i (ram_waddr_q),
    .wdata_i (ram_wdata_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_row = row_t'(ram_rdata);

  // Decode of the incoming request.
  always_comb begin
    pid_in = pid_fold(req_i.process_id);
    key_in = req_i.sem_key[KEY_W-1:0];
    key_ok = (req_i.sem_key != 8'd0) &&
             ({1'b0, req_i.sem_key} < 9'(NUM_SEMAPHORES)) && alloc_q[key_in];
  end

  // Memory read address for each step.
  always_comb begin
    case (state_q)
      S_IDLE:      ram_raddr = key_in;
      S_REL_RD:    ram_raddr = idx_q;
      S_UNL_START: ram_raddr = wait_key_q[pid_q];
      default:     ram_raddr = key_q;
    endcase
  end

  // Free-key search over one chunk of the allocation flags.
  always_comb begin
    for (int i = 0; i < NUM_CHUNKS * CHUNK; i++) begin
      free_pad[i] = (i != 0) && (i < NUM_SEMAPHORES) && !alloc_q[i];
    end
    chunk_bits = free_pad[chunk_q*CHUNK +: CHUNK];
    scan_found = 1'b0;
    scan_sel   = '0;
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (chunk_bits[j]) begin
        scan_found = 1'b1;
        scan_sel   = CHUNK_SEL_W'(j);
      end
    end
    scan_key = KEY_W'(int'(chunk_q) * CHUNK + int'(scan_sel));
  end

  // Single read port into the next-waiter links.
  always_comb begin
    nw_raddr = (state_q == S_UP) ? rd_row.head_p : cur_p_q;
    nw_rd_v  = nw_v_q[nw_raddr];
    nw_rd_p  = nw_p_q[nw_raddr];
  end

  // Candidate rows for each kind of update.
  always_comb begin
    init_sat = (32'(init_q) > 32'(CountMax)) ? CountMax : COUNT_WIDTH'(init_q);

    row_new        = '0;
    row_new.count  = init_sat;
    row_new.owner  = pid_q;

    row_dec        = rd_row;
    row_dec.count  = rd_row.count - COUNT_WIDTH'(1);

    row_enq        = rd_row;
    if (!rd_row.head_v) begin
      row_enq.head_v = 1'b1;
      row_enq.head_p = pid_q;
    end
    row_enq.tail   = pid_q;

    row_deq        = rd_row;
    row_deq.head_v = nw_rd_v;
    row_deq.head_p = nw_rd_p;

    row_inc        = rd_row;
    if (rd_row.count != CountMax) begin
      row_inc.count = rd_row.count + COUNT_WIDTH'(1);
    end

    row_unl        = row_q;
    if (!has_prev_q) begin
      row_unl.head_v = nw_rd_v;
      row_unl.head_p = nw_rd_p;
    end
    if (row_q.tail == pid_q) begin
      row_unl.tail = prev_q;
    end
  end

  // Sequencer, tables and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      alloc_q  <= '0;
      wait_v_q <= '0;
      ram_we_q <= 1'b0;
    end else begin
      ram_we_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q   <= op_e'(req_i.operation);
            key_q  <= key_in;
            pid_q  <= pid_in;
            init_q <= req_i.start_count;
            res_q  <= '0;
            case (op_e'(req_i.operation))
              OP_CREATE: begin
                chunk_q <= '0;
                state_q <= S_SCAN;
              end
              OP_DESTROY: begin
                if (!key_ok) begin
                  res_q.status <= ST_BADKEY;
                end else begin
                  alloc_q[key_in] <= 1'b0;
                  for (int p = 0; p < NUM_PROCESSES; p++) begin
                    if (wait_v_q[p] && wait_key_q[p] == key_in) begin
                      wait_v_q[p] <= 1'b0;
                    end
                  end
                end
                state_q <= S_FIN;
              end
              OP_DOWN: begin
                if (!key_ok) begin
                  res_q.status <= ST_BADKEY;
                  state_q      <= S_FIN;
                end else if (wait_v_q[pid_in]) begin
                  res_q.status <= ST_QUEUED;
                  state_q      <= S_FIN;
                end else begin
                  state_q <= S_DOWN;
                end
              end
              OP_UP: begin
                if (!key_ok) begin
                  res_q.status <= ST_BADKEY;
                  state_q      <= S_FIN;
                end else begin
                  state_q <= S_UP;
                end
              end
              OP_RELEASE: begin
                idx_q   <= KEY_W'(1);
                state_q <= S_REL_RD;
              end
              default: begin
                state_q <= S_FIN;
              end
            endcase
          end
        end

        // Lowest free key, one chunk per cycle.
        S_SCAN: begin
          if (scan_found) begin
            alloc_q[scan_key] <= 1'b1;
            ram_we_q          <= 1'b1;
            ram_waddr_q       <= scan_key;
            ram_wdata_q       <= row_new;
            res_q.new_key     <= 8'(scan_key);
            state_q           <= S_FIN;
          end else if (chunk_q == CHUNK_W'(NUM_CHUNKS - 1)) begin
            res_q.status <= ST_NOFREE;
            state_q      <= S_FIN;
          end else begin
            chunk_q <= chunk_q + CHUNK_W'(1);
          end
        end

        // Take one from the count or join the tail of the queue.
        S_DOWN: begin
          ram_we_q    <= 1'b1;
          ram_waddr_q <= key_q;
          if (rd_row.count != '0) begin
            ram_wdata_q <= row_dec;
          end else begin
            ram_wdata_q  <= row_enq;
            nw_v_q[pid_q] <= 1'b0;
            if (rd_row.head_v) begin
              nw_v_q[rd_row.tail] <= 1'b1;
              nw_p_q[rd_row.tail] <= pid_q;
            end
            wait_v_q[pid_q]   <= 1'b1;
            wait_key_q[pid_q] <= key_q;
            res_q.status      <= ST_QUEUED;
          end
          state_q <= S_FIN;
        end

        // Wake the head waiter, or add one to the count unless it is already at its maximum.
        S_UP: begin
          ram_we_q    <= 1'b1;
          ram_waddr_q <= key_q;
          if (rd_row.head_v) begin
            ram_wdata_q              <= row_deq;
            wait_v_q[rd_row.head_p]  <= 1'b0;
            res_q.woken_valid        <= 1'b1;
            res_q.woken_process      <= 4'(rd_row.head_p);
          end else begin
            ram_wdata_q <= row_inc;
          end
          state_q <= S_FIN;
        end

        // Sweep every key but the reserved key 0 and destroy those owned by the caller.
        S_REL_RD: begin
          state_q <= S_REL_CHK;
        end

        S_REL_CHK: begin
          if (alloc_q[idx_q] && rd_row.owner == pid_q) begin
            alloc_q[idx_q] <= 1'b0;
            for (int p = 0; p < NUM_PROCESSES; p++) begin
              if (wait_v_q[p] && wait_key_q[p] == idx_q) begin
                wait_v_q[p] <= 1'b0;
              end
            end
          end
          if (idx_q == KEY_W'(NUM_SEMAPHORES - 1)) begin
            state_q <= S_UNL_START;
          end else begin
            idx_q   <= idx_q + KEY_W'(1);
            state_q <= S_REL_RD;
          end
        end

        // Take the caller out of the queue it still waits in.
        S_UNL_START: begin
          if (wait_v_q[pid_q]) begin
            key_q   <= wait_key_q[pid_q];
            state_q <= S_UNL_ROW;
          end else begin
            state_q <= S_FIN;
          end
        end

        S_UNL_ROW: begin
          row_q      <= rd_row;
          cur_v_q    <= rd_row.head_v;
          cur_p_q    <= rd_row.head_p;
          prev_q     <= '0;
          has_prev_q <= 1'b0;
          state_q    <= S_UNL_WALK;
        end

        S_UNL_WALK: begin
          if (!cur_v_q) begin
            wait_v_q[pid_q] <= 1'b0;
            state_q         <= S_FIN;
          end else if (cur_p_q == pid_q) begin
            if (has_prev_q) begin
              nw_v_q[prev_q] <= nw_rd_v;
              nw_p_q[prev_q] <= nw_rd_p;
            end
            ram_we_q        <= 1'b1;
            ram_waddr_q     <= key_q;
            ram_wdata_q     <= row_unl;
            wait_v_q[pid_q] <= 1'b0;
            state_q         <= S_FIN;
          end else begin
            prev_q     <= cur_p_q;
            has_prev_q <= 1'b1;
            cur_v_q    <= nw_rd_v;
            cur_p_q    <= nw_rd_p;
          end
        end

        S_FIN: begin
          if (res_take_i) begin
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_FIN);
  assign res_o       = res_q;

  // A result that is not taken stays put.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && !res_take_i) |=> (state_q == S_FIN && $stable(res_q)))
    else $error("result changed while waiting to be taken");

  // A successful create never hands out the reserved key.
  a_create_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && op_q == OP_CREATE && res_q.status == ST_OK)
      |-> (res_q.new_key != 8'd0))
    else $error("create returned the reserved key");

  // Only up wakes a waiter.
  a_woken_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && res_q.woken_valid) |-> (op_q == OP_UP))
    else $error("waiter woken by an operation other than up");

  // The reserved key is never marked as allocated.
  a_key0: assert property (@(posedge clk_i) disable iff (!rst_ni) !alloc_q[0])
    else $error("reserved key marked as allocated");

endmodule

`default_nettype wire

### src/counting_semaphore_table.sv
// Operations: destroy finishes from idle; down and up read the row, then update
// it; create scans 16 keys per cycle; release sweeps the keys for the owner, then
// walks the queue entry by entry to unlink the caller.
// Throughput: one beat in flight; the next is taken once the sequencer returns
// to idle, while the previous result may still wait in the output register.
// Reset: allocation flags and wait flags clear at once; no clearing pass.
// ----------------------------------------------------------------------------
// Counting semaphore table
// Semaphores with FIFO wait queues behind a valid/stall request channel and
// a registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_table (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] operation_i,
  input  wire logic [7:0] sem_key_i,
  input  wire logic [3:0] process_id_i,
  input  wire logic [7:0] start_count_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      status_o,
  output logic [7:0]      new_key_o,
  output logic            woken_valid_o,
  output logic [3:0]      woken_process_o
);
  import cst_pkg::*;

  logic    busy;
  logic    start;
  req_t    req;
  logic    res_valid;
  result_t res;
  logic    out_free;
  logic    out_valid_q;
  result_t out_q;

  // Request beat is taken whenever the sequencer is idle.
  assign start = in_valid_i && !busy;
  assign req   = '{operation:   operation_i,
                   sem_key:     sem_key_i,
                   process_id:  process_id_i,
                   start_count: start_count_i};

  cst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (out_free)
  );

  // Output register; it loads when empty or when its beat is taken.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o      = busy;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign new_key_o       = out_q.new_key;
  assign woken_valid_o   = out_q.woken_valid;
  assign woken_process_o = out_q.woken_process;

endmodule

`default_nettype wire
